@@ sv/lbta_pkg.sv @@
// package for the linked block table allocator
// holds the status codes and the sequencer state encoding; no dependencies
package lbta_pkg;

	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_SHORT    = 2'd1,
		ST_BADARG   = 2'd2,
		ST_MISMATCH = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_INIT = 4'b0001,
		S_IDLE = 4'b0010,
		S_WALK = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

endpackage

@@ sv/lbta_ram.sv @@
// generic single write port, single read port ram with registered read data
// no dependencies
module lbta_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ sv/linked_block_table_allocator.sv @@
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_ready  | mode, block_index, block_count
// out     | output    | out_valid / out_ready| status, head_block, free_blocks
//
// a request walks its chain through the link table before its result; an argument
// error or short free list found at acceptance skips the walk; the link walk reads
// one table entry per cycle from a single ram read port.
// after reset an init pass rebuilds the free list, writing every link, with in_ready low.
// a chain mismatch repeats that pass before its result.
// the result register lets a new request be taken while a result waits.
// top level of the allocator; uses lbta_pkg and lbta_ram
module linked_block_table_allocator import lbta_pkg::*; #(
	parameter int BLOCKS = 16,
	localparam int IW = $clog2(BLOCKS),
	localparam int CW = $clog2(BLOCKS + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          mode,
	input  logic [IW-1:0] block_index,
	input  logic [CW-1:0] block_count,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [1:0]    status,
	output logic [IW-1:0] head_block,
	output logic [CW-1:0] free_blocks
);

	localparam logic [CW-1:0] END_MARK = CW'(BLOCKS);
	localparam logic [IW-1:0] LAST_IDX = IW'(BLOCKS - 1);

	state_t        state_q;
	logic [IW-1:0] ptr_q;
	logic [CW-1:0] free_head_q;
	logic [CW-1:0] free_count_q;
	logic          mode_q;
	logic [IW-1:0] idx_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] rem_q;
	logic [IW-1:0] cur_q;
	logic          mis_q;
	status_t       res_status_q;
	logic [IW-1:0] res_head_q;
	logic          out_valid_q;
	status_t       status_q;
	logic [IW-1:0] head_q;
	logic [CW-1:0] free_q;

	logic          accept;
	logic          bad_arg;
	logic          short_list;
	logic          last_step;
	logic          rd_end;
	logic          ram_we;
	logic [IW-1:0] ram_waddr;
	logic [CW-1:0] ram_wdata;
	logic [IW-1:0] ram_raddr;
	logic [CW-1:0] ram_rdata;
	logic          out_load;

	lbta_ram #(
		.WIDTH(CW),
		.DEPTH(BLOCKS)
	) u_link_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign in_ready = (state_q == S_IDLE);
	assign accept = in_valid && in_ready;

	assign bad_arg = (block_count == '0) || (block_count > END_MARK) ||
		((mode == MODE_FREE) &&
		 (({1'b0, block_index} >= (IW+1)'(BLOCKS)) ||
		  (({1'b0, free_count_q} + {1'b0, block_count}) > (CW+1)'(BLOCKS))));

	assign short_list = (mode == MODE_ALLOC) &&
		((block_count > free_count_q) || (free_head_q >= END_MARK));

	assign last_step = (rem_q == CW'(1));
	assign rd_end = (ram_rdata >= END_MARK);
	assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready);

	always_comb begin
		ram_we = 1'b0;
		ram_waddr = cur_q;
		ram_wdata = END_MARK;
		ram_raddr = cur_q;
		unique case (state_q)
			S_INIT: begin
				ram_we = 1'b1;
				ram_waddr = ptr_q;
				ram_wdata = CW'(ptr_q) + CW'(1);
			end
			S_IDLE: begin
				ram_raddr = (mode == MODE_FREE) ? block_index : free_head_q[IW-1:0];
			end
			S_WALK: begin
				if (last_step) begin
					ram_we = (mode_q == MODE_ALLOC) || (ram_rdata == END_MARK);
					ram_wdata = (mode_q == MODE_ALLOC) ? END_MARK : free_head_q;
				end else begin
					ram_raddr = ram_rdata[IW-1:0];
				end
			end
			S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			ptr_q <= '0;
			free_head_q <= '0;
			free_count_q <= END_MARK;
			mode_q <= MODE_ALLOC;
			idx_q <= '0;
			cnt_q <= '0;
			rem_q <= '0;
			cur_q <= '0;
			mis_q <= 1'b0;
			res_status_q <= ST_OK;
			res_head_q <= '0;
			out_valid_q <= 1'b0;
			status_q <= ST_OK;
			head_q <= '0;
			free_q <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_INIT: begin
					if (ptr_q == LAST_IDX) begin
						ptr_q <= '0;
						free_head_q <= '0;
						free_count_q <= END_MARK;
						mis_q <= 1'b0;
						if (mis_q) begin
							res_status_q <= ST_MISMATCH;
							res_head_q <= '0;
							state_q <= S_DONE;
						end else begin
							state_q <= S_IDLE;
						end
					end else begin
						ptr_q <= ptr_q + IW'(1);
					end
				end
				S_IDLE: begin
					if (accept) begin
						mode_q <= mode;
						idx_q <= block_index;
						cnt_q <= block_count;
						rem_q <= block_count;
						cur_q <= ram_raddr;
						res_head_q <= '0;
						if (bad_arg) begin
							res_status_q <= ST_BADARG;
							state_q <= S_DONE;
						end else if (short_list) begin
							res_status_q <= ST_SHORT;
							state_q <= S_DONE;
						end else begin
							state_q <= S_WALK;
						end
					end
				end
				S_WALK: begin
					if (last_step) begin
						if (mode_q == MODE_ALLOC) begin
							free_head_q <= ram_rdata;
							free_count_q <= free_count_q - cnt_q;
							res_status_q <= ST_OK;
							res_head_q <= free_head_q[IW-1:0];
							state_q <= S_DONE;
						end else if (ram_rdata == END_MARK) begin
							free_head_q <= CW'(idx_q);
							free_count_q <= free_count_q + cnt_q;
							res_status_q <= ST_OK;
							state_q <= S_DONE;
						end else begin
							mis_q <= 1'b1;
							state_q <= S_INIT;
						end
					end else if (rd_end) begin
						if (mode_q == MODE_ALLOC) begin
							res_status_q <= ST_SHORT;
							state_q <= S_DONE;
						end else begin
							mis_q <= 1'b1;
							state_q <= S_INIT;
						end
					end else begin
						cur_q <= ram_rdata[IW-1:0];
						rem_q <= rem_q - CW'(1);
					end
				end
				S_DONE: begin
					if (out_load) begin
						status_q <= res_status_q;
						head_q <= res_head_q;
						free_q <= free_count_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_INIT;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign head_block = head_q;
	assign free_blocks = free_q;

`ifndef SYNTH
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		free_count_q <= END_MARK)
		else $error("free count above pool size");

	a_zero_count: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (block_count == '0) |=> (state_q == S_DONE) && (res_status_q == ST_BADARG))
		else $error("zero count not rejected");

	a_walk_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK) |-> (rem_q != '0))
		else $error("walk with no links left");

	a_mismatch_reinit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_MISMATCH) |-> (free_blocks == END_MARK))
		else $error("mismatch without table reinit");
`endif

endmodule

@@ verif/linked_block_table_allocator_test.sv @@
// self-checking testbench for linked_block_table_allocator, built on lbta_pkg
// a request-level predictor of the link table, free head and free count computes each result
// directed cases first, then random allocate/free traffic under three idle profiles
module linked_block_table_allocator_test import lbta_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int BLOCKS = 16;
	localparam logic [4:0] END_MARK = 5'd16;
	localparam int STALL_LIMIT = 4000;
	localparam int TAIL_CYCLES = 40;

	typedef struct packed {
		status_t    status;
		logic [3:0] head;
		logic [4:0] free_cnt;
	} alloc_result_t;

	typedef struct {
		logic [3:0] head;
		logic [4:0] len;
	} chain_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic       mode = 1'b0;
	logic [3:0] block_index = '0;
	logic [4:0] block_count = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [1:0] status;
	logic [3:0] head_block;
	logic [4:0] free_blocks;

	logic [4:0] pool_link [BLOCKS];
	logic [4:0] pool_head;
	logic [4:0] pool_free;

	alloc_result_t expected_results[$];
	alloc_result_t want;
	chain_t        held_chains[$];

	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int errors = 0;
	int requests_sent = 0;
	int results_checked = 0;
	int status_seen [4] = '{0, 0, 0, 0};
	int stall_cycles = 0;

	linked_block_table_allocator #(.BLOCKS(BLOCKS)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(mode),
		.block_index(block_index),
		.block_count(block_count),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.head_block(head_block),
		.free_blocks(free_blocks)
	);

	always #1 clk = ~clk;

	function automatic void pool_reset();
		for (int b = 0; b < BLOCKS; b++) begin
			pool_link[b] = 5'(b + 1);
		end
		pool_link[BLOCKS - 1] = END_MARK;
		pool_head = 5'd0;
		pool_free = 5'(BLOCKS);
	endfunction

	function automatic alloc_result_t apply_request(logic m, logic [3:0] idx, logic [4:0] cnt);
		alloc_result_t res;
		logic [4:0] walk;
		logic [4:0] last;
		bit ok;
		res.status = ST_OK;
		res.head = '0;
		ok = 1'b1;
		if (cnt == 0 || int'(cnt) > BLOCKS) begin
			res.status = ST_BADARG;
		end else if (m == MODE_ALLOC) begin
			if (cnt > pool_free || int'(pool_head) >= BLOCKS) begin
				res.status = ST_SHORT;
			end else begin
				walk = pool_head;
				last = walk;
				for (int k = 0; k < int'(cnt); k++) begin
					if (int'(walk) >= BLOCKS) begin
						ok = 1'b0;
						break;
					end
					last = walk;
					walk = pool_link[walk[3:0]];
				end
				if (!ok) begin
					res.status = ST_SHORT;
				end else begin
					res.head = pool_head[3:0];
					pool_link[last[3:0]] = END_MARK;
					pool_head = walk;
					pool_free = pool_free - cnt;
				end
			end
		end else begin
			if (int'(pool_free) + int'(cnt) > BLOCKS) begin
				res.status = ST_BADARG;
			end else begin
				walk = {1'b0, idx};
				for (int k = 1; k < int'(cnt); k++) begin
					walk = pool_link[walk[3:0]];
					if (int'(walk) >= BLOCKS) begin
						ok = 1'b0;
						break;
					end
				end
				if (ok && pool_link[walk[3:0]] != END_MARK) ok = 1'b0;
				if (!ok) begin
					pool_reset();
					res.status = ST_MISMATCH;
				end else begin
					pool_link[walk[3:0]] = pool_head;
					pool_head = {1'b0, idx};
					pool_free = pool_free + cnt;
				end
			end
		end
		res.free_cnt = pool_free;
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [4:0] got, input logic [4:0] exp_val);
		$display("error at %0t: %s got %0d expected %0d", $realtime, what, got, exp_val);
		errors++;
	endtask

	// sends one transaction, then records its predicted result and the chain bookkeeping
	task automatic send_request(input logic m, input logic [3:0] idx, input logic [4:0] cnt);
		int gap;
		alloc_result_t res;
		gap = 0;
		while ($urandom_range(99) < tx_idle_pct && gap < 20) gap++;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		block_index <= idx;
		block_count <= cnt;
		do @(posedge clk); while (!in_ready);
		res = apply_request(m, idx, cnt);
		expected_results.push_back(res);
		requests_sent++;
		status_seen[int'(res.status)]++;
		if (res.status == ST_MISMATCH) begin
			held_chains.delete();
		end else if (res.status == ST_OK && m == MODE_ALLOC) begin
			held_chains.push_back('{res.head, cnt});
		end else if (res.status == ST_OK) begin
			for (int p = 0; p < held_chains.size(); p++) begin
				if (held_chains[p].head == idx && held_chains[p].len == cnt) begin
					held_chains.delete(p);
					break;
				end
			end
		end
	endtask

	task automatic wait_for_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_results.size() != 0);
	endtask

	task automatic test_bad_arguments();
		send_request(MODE_FREE, 4'd0, 5'd1);
		send_request(MODE_ALLOC, 4'd0, 5'd0);
		send_request(MODE_FREE, 4'd15, 5'd0);
		send_request(MODE_ALLOC, 4'd0, 5'd17);
		send_request(MODE_FREE, 4'd10, 5'd31);
		wait_for_results();
	endtask

	task automatic test_full_pool_cycle();
		send_request(MODE_ALLOC, 4'd0, 5'd16);
		send_request(MODE_ALLOC, 4'd0, 5'd1);
		send_request(MODE_FREE, 4'd0, 5'd16);
		send_request(MODE_ALLOC, 4'd15, 5'd5);
		send_request(MODE_ALLOC, 4'd0, 5'd11);
		send_request(MODE_ALLOC, 4'd0, 5'd1);
		send_request(MODE_FREE, 4'd5, 5'd11);
		send_request(MODE_FREE, 4'd0, 5'd5);
		wait_for_results();
	endtask

	task automatic test_chain_mismatch();
		send_request(MODE_ALLOC, 4'd0, 5'd3);
		send_request(MODE_FREE, 4'd0, 5'd2);
		send_request(MODE_ALLOC, 4'd0, 5'd4);
		send_request(MODE_FREE, 4'd0, 5'd6);
		send_request(MODE_ALLOC, 4'd0, 5'd16);
		send_request(MODE_FREE, 4'd15, 5'd1);
		send_request(MODE_ALLOC, 4'd0, 5'd2);
		send_request(MODE_FREE, 4'd0, 5'd15);
		wait_for_results();
	endtask

	// mostly allocations and frees of held chains, with some noise and bad arguments
	task automatic test_random_traffic(input int items);
		int r;
		int pick;
		int lo;
		logic [4:0] n;
		for (int k = 0; k < items; k++) begin
			r = $urandom_range(99);
			if (r < 40 || (r < 80 && held_chains.size() == 0)) begin
				if (pool_free == 0) n = 5'($urandom_range(1, 3));
				else if ($urandom_range(9) == 0) n = 5'($urandom_range(1, 16));
				else n = 5'($urandom_range(1, (pool_free < 6) ? int'(pool_free) : 6));
				send_request(MODE_ALLOC, 4'($urandom), n);
			end else if (r < 80) begin
				pick = $urandom_range(held_chains.size() - 1);
				send_request(MODE_FREE, held_chains[pick].head, held_chains[pick].len);
			end else if (r < 88) begin
				send_request(MODE_FREE, 4'($urandom), 5'($urandom_range(1, 16)));
			end else if (r < 95) begin
				n = ($urandom_range(1) == 0) ? 5'd0 : 5'($urandom_range(17, 31));
				send_request(1'($urandom), 4'($urandom), n);
			end else begin
				lo = (int'(pool_free) + 1 > BLOCKS) ? BLOCKS : int'(pool_free) + 1;
				send_request(MODE_ALLOC, 4'($urandom), 5'($urandom_range(lo, BLOCKS)));
			end
			if (k % 150 == 149) wait_for_results();
		end
		wait_for_results();
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unrequested result, status", {3'b0, status}, 5'd0);
			end else begin
				want = expected_results.pop_front();
				if (status !== want.status)
					report_mismatch("status", {3'b0, status}, {3'b0, want.status});
				if (head_block !== want.head)
					report_mismatch("head_block", {1'b0, head_block}, {1'b0, want.head});
				if (free_blocks !== want.free_cnt)
					report_mismatch("free_blocks", free_blocks, want.free_cnt);
				results_checked++;
			end
		end
		out_ready <= ($urandom_range(99) >= rx_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
			else stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("timeout after %0d cycles without a transaction", stall_cycles);
				$display("linked_block_table_allocator: mismatch");
				$finish;
			end
		end
	end

	initial begin
		pool_reset();
		tx_idle_pct = 25;
		rx_idle_pct = 57;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		test_bad_arguments();
		test_full_pool_cycle();
		test_chain_mismatch();
		test_random_traffic(610);
		tx_idle_pct = 57;
		rx_idle_pct = 25;
		test_random_traffic(610);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		test_random_traffic(610);
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("ran %0d requests, checked %0d results", requests_sent, results_checked);
		$display("ok %0d, short %0d, bad argument %0d, chain mismatch %0d",
			status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
		if (errors == 0 && expected_results.size() == 0) begin
			$display("linked_block_table_allocator: match");
		end else begin
			$display("linked_block_table_allocator: mismatch");
		end
		$finish;
	end

endmodule
